// ===== rtl/sgst_pkg.sv =====
// sgst_pkg: shared constants and the sequencer state type for the sphere gap
// spanning tree unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sgst_pkg;

  localparam int MAX_SPHERES = 64;
  localparam int IDX_W       = $clog2(MAX_SPHERES);
  localparam int CNT_W       = $clog2(MAX_SPHERES + 1);
  localparam int COORD_W     = 20;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int SQ_W        = 2 * COORD_W + 2;
  localparam int ROOT_W      = COORD_W + 1;
  localparam int GAP_W       = 22;
  localparam int SUM_W       = 32;
  localparam int SQC_W       = $clog2(ROOT_W);

  localparam logic [GAP_W-1:0] GAP_NONE = {GAP_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VRD,
    ST_VCAP,
    ST_IRD,
    ST_DX,
    ST_DY,
    ST_DZ,
    ST_SQ,
    ST_UPD,
    ST_DONE
  } sgst_state_t;

endpackage
`default_nettype wire

// ===== rtl/sphere_gap_spanning_tree_unit.sv =====
// sphere_gap_spanning_tree_unit: sphere store plus a dense Prim sequencer
// built around one shared multiplier and a bit-serial square root.
// Depends on sgst_pkg.
//
//  channel | ports                                        | handshake
//  input   | in_pos_x/y/z, in_radius, in_last             | start && !busy
//  result  | out_total_length, out_too_many               | out_valid, one cycle
//
// A sphere word without last is taken and busy stays low.
// A word with last starts the tree pass: each round reads the newest tree sphere,
// skips spheres already in the tree and, for each one outside it, squares dx, dy
// and dz on the multiplier, then runs the 21-step square root and the update.
// busy is high from the last word until the result strobe.
// Reset is synchronous, active low; the receiver cannot stall the result.
`timescale 1ns / 1ps
`default_nettype none
module sphere_gap_spanning_tree_unit import sgst_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire  [COORD_W-1:0] in_pos_x,
  input  wire  [COORD_W-1:0] in_pos_y,
  input  wire  [COORD_W-1:0] in_pos_z,
  input  wire  [COORD_W-1:0] in_radius,
  input  wire                in_last,
  output logic               out_valid,
  output logic [SUM_W-1:0]   out_total_length,
  output logic               out_too_many
);

  localparam int WORD_W = 4 * COORD_W;
  localparam logic [SQ_W-1:0] BIT_TOP = SQ_W'(1) << (2 * (ROOT_W - 1));

  sgst_state_t state_r, state_nxt;

  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0]       i_r, i_nxt;
  logic [IDX_W-1:0]       v_r, v_nxt;
  logic [GAP_W-1:0]       vbest_r, vbest_nxt;
  logic [IDX_W-1:0]       cand_r, cand_nxt;
  logic [GAP_W-1:0]       cbest_r, cbest_nxt;
  logic                   found_r, found_nxt;
  logic [MAX_SPHERES-1:0] tree_r, tree_nxt;
  logic [MAX_SPHERES-1:0] bval_r, bval_nxt;
  logic [COORD_W-1:0]     vx_r, vy_r, vz_r, vr_r;
  logic [COORD_W-1:0]     vx_nxt, vy_nxt, vz_nxt, vr_nxt;
  logic [SQ_W-1:0]        acc_r, acc_nxt;
  logic [SQ_W-1:0]        res_r, res_nxt;
  logic [SQ_W-1:0]        bit_r, bit_nxt;
  logic [SQC_W-1:0]       sqc_r, sqc_nxt;

  // sphere store and candidate gap store
  logic [WORD_W-1:0] sph_mem [MAX_SPHERES];
  logic [GAP_W-1:0]  gap_mem [MAX_SPHERES];
  logic [WORD_W-1:0] sph_rd_r;
  logic [GAP_W-1:0]  gap_rd_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              sph_we;
  logic              gap_we;
  logic [GAP_W-1:0]  gap_wd;

  logic              accept;
  logic [COORD_W-1:0] ix, iy, iz, ir;
  logic [COORD_W-1:0] mul_op;
  logic [PROD_W-1:0]  prod;
  logic [SQ_W:0]      trial;
  logic [SUM_W:0]     sum_ext;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W-1:0]  rsum;
  logic [GAP_W-1:0]   gap;
  logic [GAP_W-1:0]   old_best;
  logic [GAP_W-1:0]   new_best;

  assign accept = start && !busy;
  assign {ix, iy, iz, ir} = sph_rd_r;

  // sphere store write at the current fill count, gap store write at the scan index, registered reads
  always_ff @(posedge clk) begin
    if (sph_we) begin
      sph_mem[cnt_r[IDX_W-1:0]] <= {in_pos_x, in_pos_y, in_pos_z, in_radius};
    end
    if (gap_we) begin
      gap_mem[i_r[IDX_W-1:0]] <= gap_wd;
    end
    sph_rd_r <= sph_mem[rd_addr];
    gap_rd_r <= gap_mem[rd_addr];
  end

  // shared multiplier operand: absolute coordinate difference
  always_comb begin
    unique case (state_r)
      ST_DX:   mul_op = (ix > vx_r) ? ix - vx_r : vx_r - ix;
      ST_DY:   mul_op = (iy > vy_r) ? iy - vy_r : vy_r - iy;
      default: mul_op = (iz > vz_r) ? iz - vz_r : vz_r - iz;
    endcase
  end
  assign prod = PROD_W'(mul_op) * PROD_W'(mul_op);

  assign trial    = {1'b0, res_r} + {1'b0, bit_r};
  assign sum_ext  = {1'b0, sum_r} + (SUM_W + 1)'(vbest_r);
  assign root     = res_r[ROOT_W-1:0];
  assign rsum     = ROOT_W'(vr_r) + ROOT_W'(ir);
  assign gap      = (root > rsum) ? GAP_W'(root - rsum) : '0;
  assign old_best = bval_r[i_r[IDX_W-1:0]] ? gap_rd_r : GAP_NONE;
  assign new_best = (gap < old_best) ? gap : old_best;

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      sum_r   <= sum_nxt;
    end
    i_r     <= i_nxt;
    v_r     <= v_nxt;
    vbest_r <= vbest_nxt;
    cand_r  <= cand_nxt;
    cbest_r <= cbest_nxt;
    found_r <= found_nxt;
    tree_r  <= tree_nxt;
    bval_r  <= bval_nxt;
    vx_r    <= vx_nxt;
    vy_r    <= vy_nxt;
    vz_r    <= vz_nxt;
    vr_r    <= vr_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
    bit_r   <= bit_nxt;
    sqc_r   <= sqc_nxt;
  end

  // sequencer: load, then per round pick v, relax every sphere outside the tree
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    sum_nxt   = sum_r;
    i_nxt     = i_r;
    v_nxt     = v_r;
    vbest_nxt = vbest_r;
    cand_nxt  = cand_r;
    cbest_nxt = cbest_r;
    found_nxt = found_r;
    tree_nxt  = tree_r;
    bval_nxt  = bval_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    vz_nxt    = vz_r;
    vr_nxt    = vr_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    sqc_nxt   = sqc_r;
    rd_addr   = i_r[IDX_W-1:0];
    sph_we    = 1'b0;
    gap_we    = 1'b0;
    gap_wd    = new_best;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          if (cnt_r < CNT_W'(MAX_SPHERES)) begin
            sph_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            v_nxt     = '0;
            vbest_nxt = '0;
            tree_nxt  = '0;
            bval_nxt  = '0;
            sum_nxt   = '0;
            state_nxt = ST_VRD;
          end
        end
      end
      ST_VRD: begin
        rd_addr   = v_r;
        state_nxt = ST_VCAP;
      end
      ST_VCAP: begin
        {vx_nxt, vy_nxt, vz_nxt, vr_nxt} = sph_rd_r;
        tree_nxt[v_r] = 1'b1;
        sum_nxt   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        i_nxt     = '0;
        found_nxt = 1'b0;
        state_nxt = ST_IRD;
      end
      ST_IRD: begin
        if (i_r == cnt_r) begin
          if (found_r) begin
            v_nxt     = cand_r;
            vbest_nxt = cbest_r;
            state_nxt = ST_VRD;
          end else begin
            state_nxt = ST_DONE;
          end
        end else if (tree_r[i_r[IDX_W-1:0]]) begin
          i_nxt = i_r + 1'b1;
        end else begin
          state_nxt = ST_DX;
        end
      end
      ST_DX: begin
        acc_nxt   = SQ_W'(prod);
        state_nxt = ST_DY;
      end
      ST_DY: begin
        acc_nxt   = acc_r + SQ_W'(prod);
        state_nxt = ST_DZ;
      end
      ST_DZ: begin
        acc_nxt   = acc_r + SQ_W'(prod);
        res_nxt   = '0;
        bit_nxt   = BIT_TOP;
        sqc_nxt   = SQC_W'(ROOT_W - 1);
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        // one digit of the square root per cycle
        if ({1'b0, acc_r} >= trial) begin
          acc_nxt = acc_r - trial[SQ_W-1:0];
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        sqc_nxt = sqc_r - 1'b1;
        if (sqc_r == '0) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        gap_we = 1'b1;
        bval_nxt[i_r[IDX_W-1:0]] = 1'b1;
        if (!found_r || new_best < cbest_r) begin
          cand_nxt  = i_r[IDX_W-1:0];
          cbest_nxt = new_best;
          found_nxt = 1'b1;
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = ST_IRD;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        cnt_nxt   = '0;
        ovf_nxt   = 1'b0;
        sum_nxt   = '0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_total_length = sum_r;
  assign out_too_many     = ovf_r;

  // checks
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("not idle after result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SPHERES))
    else $error("sphere count beyond store depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IRD) |-> (i_r <= cnt_r))
    else $error("scan index past sphere count");

endmodule
`default_nettype wire
